FILE: design/drd_pkg.sv
// Shared types and constants of the detection row decoder.
// No dependencies; compile first.
`default_nettype none

package drd_pkg;

   // Largest number of class scores in one row
   localparam int MAX_CLASSES = 128;
   // Network input side limits, whole pixels
   localparam int MAX_INPUT_SIZE = 1024;
   // Elements ahead of the class scores: cx, cy, w, h, objectness
   localparam int BOX_ELEMENTS = 5;

   localparam int VALUE_W = 16;
   localparam int LABEL_W = 7;
   localparam int POS_W = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [7:0]  CLASS_COUNT_RST = 8'd80;
   localparam logic [15:0] OBJ_THRESHOLD_RST = 16'd32768;
   localparam logic [15:0] CONF_THRESHOLD_RST = 16'd32768;
   localparam logic [10:0] INPUT_SIZE_RST = 11'd320;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLASS_COUNT    = 8'd0,
      CSR_OBJ_THRESHOLD  = 8'd1,
      CSR_CONF_THRESHOLD = 8'd2,
      CSR_INPUT_SIZE     = 8'd3
   } csr_index_type;

   // Input word: one row element
   typedef struct packed {
      logic [VALUE_W-1:0] element_value;
   } req_word_type;

   // Result word: one decoded box
   typedef struct packed {
      logic [VALUE_W-1:0] left_x;
      logic [VALUE_W-1:0] top_y;
      logic [VALUE_W-1:0] right_x;
      logic [VALUE_W-1:0] bottom_y;
      logic [VALUE_W-1:0] score;
      logic [LABEL_W-1:0] class_label;
   } rsp_word_type;

   // Finished row handed from the row collector to the decode stage
   typedef struct packed {
      logic [VALUE_W-1:0] center_x;
      logic [VALUE_W-1:0] center_y;
      logic [VALUE_W-1:0] box_width;
      logic [VALUE_W-1:0] box_height;
      logic [VALUE_W-1:0] objectness;
      logic [VALUE_W-1:0] best_score;
      logic [LABEL_W-1:0] best_label;
   } row_word_type;

endpackage

`default_nettype wire

FILE: design/drd_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from drd_pkg at instantiation.
`default_nettype none

interface drd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/detection_row_decode.sv
// Top level of the detection row decoder: row collector, decode stage, CSRs.
// Depends on drd_pkg and drd_stream_if.
//
//   channel   dir   word                         handshake
//   req_bus   in    element_value (16b)          valid/ready
//   rsp_bus   out   corners, score, class_label  valid/ready
//   csr_*     in    index, 16b data              write enable only
//
// One element is taken per cycle while req_bus.ready is high; a row holds 5 +
// class_count elements, class_count clamped to 1..128. A kept row passes the
// decode stage, holding one finished row, and the output register, holding one
// box; so input keeps flowing while a box waits, and req_bus.ready drops only
// when both are full. The 16x16 score multiply sets the longest path.
// Synchronous reset sets CSR defaults, clears row position and both valid flags.
`default_nettype none

module detection_row_decode (
   input  wire logic                              clock,
   input  wire logic                              reset,
   drd_stream_if.sink                             req_bus,
   drd_stream_if.source                           rsp_bus,
   input  wire logic                              csr_wr_en,
   input  wire logic [drd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [drd_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int VW = drd_pkg::VALUE_W;
   localparam int LW = drd_pkg::LABEL_W;
   localparam int PW = drd_pkg::POS_W;

   // Configuration registers
   logic [7:0]    class_count_ff;
   logic [VW-1:0] obj_threshold_ff;
   logic [VW-1:0] conf_threshold_ff;
   logic [10:0]   input_size_ff;

   // Row collector state
   logic [PW-1:0] row_position_ff, row_position_in;
   logic [VW-1:0] center_x_ff, center_x_in;
   logic [VW-1:0] center_y_ff, center_y_in;
   logic [VW-1:0] box_width_ff, box_width_in;
   logic [VW-1:0] box_height_ff, box_height_in;
   logic [VW-1:0] objectness_ff, objectness_in;
   logic [VW-1:0] best_score_ff, best_score_in;
   logic [LW-1:0] best_label_ff, best_label_in;

   // Decode stage and output register
   logic                  s1_valid_ff, s1_valid_in;
   drd_pkg::row_word_type s1_row_ff, s1_row_in;
   logic                  out_valid_ff, out_valid_in;
   drd_pkg::rsp_word_type out_word_ff, out_word_in;

   logic          accept;
   logic          out_free;
   logic          s1_free;
   logic [VW-1:0] elem;
   logic [8:0]    eff_classes;
   logic [8:0]    last_pos;
   logic          is_last;
   logic [PW-1:0] label_pos;
   logic [10:0]   size_clamped;
   logic [10:0]   size_m1;
   logic [VW-1:0] upper_lim;
   logic [31:0]   product;
   logic          row_pass;

   // Low corner: floor((2c - d) / 2), saturated at zero
   function automatic logic [15:0] low_corner(input logic [15:0] c, input logic [15:0] d);
      logic [16:0] twice;
      logic [16:0] diff;
      twice = {c, 1'b0};
      diff = twice - {1'b0, d};
      if (twice < {1'b0, d}) begin
         return 16'd0;
      end
      return diff[16:1];
   endfunction

   // High corner: floor((2c + d) / 2), clamped to lim
   function automatic logic [15:0] high_corner(input logic [15:0] c, input logic [15:0] d,
                                               input logic [15:0] lim);
      logic [17:0] sum;
      logic [16:0] half;
      sum = {1'b0, c, 1'b0} + {2'b0, d};
      half = sum[17:1];
      if (half > {1'b0, lim}) begin
         return lim;
      end
      return half[15:0];
   endfunction

   // Write configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff    <= drd_pkg::CLASS_COUNT_RST;
         obj_threshold_ff  <= drd_pkg::OBJ_THRESHOLD_RST;
         conf_threshold_ff <= drd_pkg::CONF_THRESHOLD_RST;
         input_size_ff     <= drd_pkg::INPUT_SIZE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            drd_pkg::CSR_CLASS_COUNT:    class_count_ff    <= csr_wr_data[7:0];
            drd_pkg::CSR_OBJ_THRESHOLD:  obj_threshold_ff  <= csr_wr_data[15:0];
            drd_pkg::CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_wr_data[15:0];
            drd_pkg::CSR_INPUT_SIZE:     input_size_ff     <= csr_wr_data[10:0];
            default: ;
         endcase
      end
   end

   // Handshake: the decode stage frees up whenever the output register moves on
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign s1_free = !s1_valid_ff || out_free;
   assign req_bus.ready = s1_free;
   assign accept = req_bus.valid && s1_free;
   assign elem = req_bus.payload.element_value;

   // Clamp class count to 1..MAX_CLASSES and find the row's last position
   always_comb begin
      if (class_count_ff == 8'd0) begin
         eff_classes = 9'd1;
      end else if ({1'b0, class_count_ff} > 9'(drd_pkg::MAX_CLASSES)) begin
         eff_classes = 9'(drd_pkg::MAX_CLASSES);
      end else begin
         eff_classes = {1'b0, class_count_ff};
      end
      last_pos = 9'(drd_pkg::BOX_ELEMENTS - 1) + eff_classes;
      is_last = {1'b0, row_position_ff} >= last_pos;
      label_pos = row_position_ff - PW'(drd_pkg::BOX_ELEMENTS);
   end

   // Collect the row: store box fields, run the argmax, advance the position
   always_comb begin
      row_position_in = row_position_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      box_width_in = box_width_ff;
      box_height_in = box_height_ff;
      objectness_in = objectness_ff;
      best_score_in = best_score_ff;
      best_label_in = best_label_ff;
      if (accept) begin
         case (row_position_ff)
            8'd0: center_x_in = elem;
            8'd1: center_y_in = elem;
            8'd2: box_width_in = elem;
            8'd3: box_height_in = elem;
            8'd4: objectness_in = elem;
            8'd5: begin
               best_score_in = elem;
               best_label_in = '0;
            end
            default: begin
               if (elem > best_score_ff) begin
                  best_score_in = elem;
                  best_label_in = label_pos[LW-1:0];
               end
            end
         endcase
         row_position_in = is_last ? '0 : row_position_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_position_ff <= '0;
      end else begin
         row_position_ff <= row_position_in;
      end
   end

   always_ff @(posedge clock) begin
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
      box_width_ff <= box_width_in;
      box_height_ff <= box_height_in;
      objectness_ff <= objectness_in;
      best_score_ff <= best_score_in;
      best_label_ff <= best_label_in;
   end

   // Hand a finished row to the decode stage
   always_comb begin
      s1_row_in.center_x = center_x_in;
      s1_row_in.center_y = center_y_in;
      s1_row_in.box_width = box_width_in;
      s1_row_in.box_height = box_height_in;
      s1_row_in.objectness = objectness_in;
      s1_row_in.best_score = best_score_in;
      s1_row_in.best_label = best_label_in;
      if (accept && is_last) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_last) begin
         s1_row_ff <= s1_row_in;
      end
   end

   // Decode: score product, thresholds, corner limits
   always_comb begin
      if (input_size_ff == 11'd0) begin
         size_clamped = 11'd1;
      end else if (input_size_ff > 11'(drd_pkg::MAX_INPUT_SIZE)) begin
         size_clamped = 11'(drd_pkg::MAX_INPUT_SIZE);
      end else begin
         size_clamped = input_size_ff;
      end
      size_m1 = size_clamped - 11'd1;
      upper_lim = {size_m1[9:0], 6'd0};
      product = 32'(s1_row_ff.objectness) * 32'(s1_row_ff.best_score);
      row_pass = (s1_row_ff.objectness >= obj_threshold_ff) &&
                 (product[31:16] >= conf_threshold_ff);
      out_word_in.left_x = low_corner(s1_row_ff.center_x, s1_row_ff.box_width);
      out_word_in.top_y = low_corner(s1_row_ff.center_y, s1_row_ff.box_height);
      out_word_in.right_x = high_corner(s1_row_ff.center_x, s1_row_ff.box_width, upper_lim);
      out_word_in.bottom_y = high_corner(s1_row_ff.center_y, s1_row_ff.box_height, upper_lim);
      out_word_in.score = product[31:16];
      out_word_in.class_label = s1_row_ff.best_label;
      out_valid_in = out_free ? (s1_valid_ff && row_pass) : out_valid_ff;
   end

   // Output register: load when free, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.payload = out_word_ff;

   // A stalled decode stage keeps its row
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("decode stage lost a row while stalled");

   // The row position never runs past the longest row
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_position_ff} <= 9'(drd_pkg::BOX_ELEMENTS - 1 + drd_pkg::MAX_CLASSES))
      else $error("row position out of range");

   // A shown box meets the confidence threshold
   a_score_pass: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.score >= conf_threshold_ff))
      else $error("box below confidence threshold");

   // Upper corners never exceed the clamp
   a_upper_clamp: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.right_x <= upper_lim && out_word_ff.bottom_y <= upper_lim))
      else $error("upper corner above input size");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for detection_row_decode: streams detector rows word by word and
// checks each decoded box against an in-bench predictor of the row decoder.
// Depends on drd_pkg and drd_stream_if from the design folder.
`timescale 1ns / 1ps

module testbench;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int NOISE_PERCENT = 15;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [drd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [drd_pkg::CSR_DATA_W-1:0] csr_wr_data;

   drd_stream_if #(.payload_type(drd_pkg::req_word_type)) req_bus ();
   drd_stream_if #(.payload_type(drd_pkg::rsp_word_type)) rsp_bus ();

   detection_row_decode DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Register copies kept by the predictor
   logic [7:0]  cfg_class_count = drd_pkg::CLASS_COUNT_RST;
   logic [15:0] cfg_obj_thr = drd_pkg::OBJ_THRESHOLD_RST;
   logic [15:0] cfg_conf_thr = drd_pkg::CONF_THRESHOLD_RST;
   logic [10:0] cfg_input_size = drd_pkg::INPUT_SIZE_RST;

   // Row state kept by the predictor
   logic [7:0]  row_pos = '0;
   logic [15:0] ctr_x = '0;
   logic [15:0] ctr_y = '0;
   logic [15:0] box_w = '0;
   logic [15:0] box_h = '0;
   logic [15:0] obj_val = '0;
   logic [15:0] top_score = '0;
   logic [6:0]  top_label = '0;

   drd_pkg::rsp_word_type pending_boxes[$];
   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit sender_gaps = 1'b1;
   bit sink_stalls = 1'b1;

   // Clock
   always #1 clock = ~clock;

   // Mostly short pauses, a few long ones
   function automatic int pick_pause(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int class_total();
      int n;
      n = cfg_class_count;
      if (n < 1) n = 1;
      if (n > drd_pkg::MAX_CLASSES) n = drd_pkg::MAX_CLASSES;
      return n;
   endfunction

   // floor(c - d/2), saturated at zero
   function automatic logic [15:0] low_edge(int unsigned c, int unsigned d);
      if (2 * c < d) return '0;
      return 16'((2 * c - d) >> 1);
   endfunction

   // floor(c + d/2), clamped to the top pixel of the input
   function automatic logic [15:0] high_edge(int unsigned c, int unsigned d,
                                             int unsigned lim);
      int unsigned v;
      v = (2 * c + d) >> 1;
      return 16'((v > lim) ? lim : v);
   endfunction

   // Advance the row by one word; queue a box when a kept row ends
   function automatic void decode_element(logic [15:0] v);
      int unsigned last_pos, side, lim, prod;
      drd_pkg::rsp_word_type box;
      last_pos = 4 + class_total();
      case (row_pos)
         8'd0: ctr_x = v;
         8'd1: ctr_y = v;
         8'd2: box_w = v;
         8'd3: box_h = v;
         8'd4: obj_val = v;
         default: begin
            if (row_pos == drd_pkg::BOX_ELEMENTS) begin
               top_score = v;
               top_label = '0;
            end else if (v > top_score) begin
               top_score = v;
               top_label = 7'(row_pos - drd_pkg::BOX_ELEMENTS);
            end
         end
      endcase
      if (row_pos < drd_pkg::BOX_ELEMENTS || row_pos < last_pos) begin
         row_pos = row_pos + 8'd1;
         return;
      end
      row_pos = '0;
      if (obj_val < cfg_obj_thr) return;
      prod = obj_val * top_score;
      if (prod < {cfg_conf_thr, 16'h0000}) return;
      side = cfg_input_size;
      if (side < 1) side = 1;
      if (side > drd_pkg::MAX_INPUT_SIZE) side = drd_pkg::MAX_INPUT_SIZE;
      lim = (side - 1) << 6;
      box.left_x = low_edge(ctr_x, box_w);
      box.top_y = low_edge(ctr_y, box_h);
      box.right_x = high_edge(ctr_x, box_w, lim);
      box.bottom_y = high_edge(ctr_y, box_h, lim);
      box.score = prod[31:16];
      box.class_label = top_label;
      pending_boxes.insert(pending_boxes.size(), box);
   endfunction

   // Hand one word to the block, then predict on acceptance
   task automatic send_element(logic [15:0] value);
      int gap;
      gap = pick_pause(sender_gaps);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.payload.element_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      decode_element(value);
   endtask

   task automatic csr_write(logic [drd_pkg::CSR_INDEX_W-1:0] idx,
                            logic [drd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         drd_pkg::CSR_CLASS_COUNT: cfg_class_count = data[7:0];
         drd_pkg::CSR_OBJ_THRESHOLD: cfg_obj_thr = data;
         drd_pkg::CSR_CONF_THRESHOLD: cfg_conf_thr = data;
         drd_pkg::CSR_INPUT_SIZE: cfg_input_size = data[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold input until every box has arrived and dropped rows have cleared
   task automatic drain_pipeline();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(logic [15:0] classes, logic [15:0] obj_thr,
                                logic [15:0] conf_thr, logic [15:0] side);
      drain_pipeline();
      csr_write(drd_pkg::CSR_CLASS_COUNT, classes);
      csr_write(drd_pkg::CSR_OBJ_THRESHOLD, obj_thr);
      csr_write(drd_pkg::CSR_CONF_THRESHOLD, conf_thr);
      csr_write(drd_pkg::CSR_INPUT_SIZE, side);
   endtask

   // One-class row: fixed box fields, given objectness and class score
   task automatic send_box_row(logic [15:0] obj, logic [15:0] best);
      send_element(16'd6400);
      send_element(16'd3200);
      send_element(16'd1280);
      send_element(16'd640);
      send_element(obj);
      send_element(best);
   endtask

   function automatic logic [15:0] box_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r < 5) return 16'($urandom_range(0, 2047));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Well-formed row biased toward passing, or a row of random words
   task automatic send_row(bit noise);
      int n, hot, i;
      logic [15:0] best;
      n = class_total();
      if (noise) begin
         repeat (drd_pkg::BOX_ELEMENTS + n) send_element(16'($urandom_range(0, 65535)));
      end else begin
         repeat (4) send_element(box_coord());
         if ($urandom_range(0, 3) != 0)
            send_element(16'($urandom_range(cfg_obj_thr, 65535)));
         else
            send_element(16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 9) < 7)
            best = 16'($urandom_range(cfg_conf_thr, 65535));
         else
            best = 16'($urandom_range(0, 65535));
         hot = $urandom_range(0, n - 1);
         for (i = 0; i < n; i++) begin
            if (i == hot || $urandom_range(0, 7) == 0)
               send_element(best);
            else
               send_element(16'($urandom_range(0, best)));
         end
      end
   endtask

   task automatic run_phase(logic [15:0] classes, logic [15:0] obj_thr,
                            logic [15:0] conf_thr, logic [15:0] side, int rows,
                            bit gaps);
      set_registers(classes, obj_thr, conf_thr, side);
      // Out-of-range index must leave every register alone
      csr_write(drd_pkg::CSR_INDEX_W'($urandom_range(drd_pkg::CSR_INPUT_SIZE + 1, 255)),
                drd_pkg::CSR_DATA_W'($urandom_range(0, 65535)));
      sender_gaps = gaps;
      sink_stalls = gaps ? 1'b1 : 1'($urandom_range(0, 1));
      repeat (rows) send_row($urandom_range(0, 99) < NOISE_PERCENT);
   endtask

   // Field extremes: saturating corners, clamp, tie on the best score
   task automatic test_extremes();
      set_registers(16'd2, 16'd0, 16'd0, 16'd320);
      send_element(16'h0000);
      send_element(16'h0000);
      send_element(16'hFFFF);
      send_element(16'hFFFF);
      send_element(16'hFFFF);
      send_element(16'hFFFF);
      send_element(16'hFFFF);
   endtask

   // Rows at and just below each threshold
   task automatic test_thresholds();
      set_registers(16'd1, 16'd32768, 16'd1000, 16'd1024);
      send_box_row(16'd32767, 16'hFFFF);
      send_box_row(16'd32768, 16'd2000);
      send_box_row(16'd32768, 16'd1999);
   endtask

   // Lower the class count mid-row so the next score closes the row
   task automatic test_count_lowered();
      set_registers(16'd4, 16'd0, 16'd0, 16'd320);
      send_element(16'd1000);
      send_element(16'd2000);
      send_element(16'd300);
      send_element(16'd500);
      send_element(16'd60000);
      send_element(16'd100);
      send_element(16'd200);
      send_element(16'd50);
      drain_pipeline();
      csr_write(drd_pkg::CSR_CLASS_COUNT, 16'd1);
      send_element(16'd40000);
   endtask

   task automatic test_random_rows();
      run_phase(16'd1, 16'd0, 16'd0, 16'd1024, 10, 1'b1);
      run_phase(16'd3, 16'd16384, 16'd8192, 16'hF940, 10, 1'b0);
      run_phase(16'd0, 16'd65535, 16'd0, 16'd0, 10, 1'b1);
      run_phase(16'hFF04, 16'd0, 16'd65535, 16'd2047, 8, 1'b1);
      run_phase(16'd2, 16'd32768, 16'd32768, 16'd640, 5, 1'b1);
      run_phase(16'd128, 16'd8192, 16'd4096, 16'd512, 1, 1'b1);
      run_phase(16'd200, 16'd4096, 16'd4096, 16'd100, 1, 1'b1);
   endtask

   // Result-side backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left <= pick_pause(sink_stalls);
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare each accepted box with the oldest prediction
   always @(posedge clock) begin
      drd_pkg::rsp_word_type want, got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (pending_boxes.size() == 0) begin
            $display("%0t: unexpected box: expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_boxes.pop_front();
            check_field("left_x", want.left_x, got.left_x);
            check_field("top_y", want.top_y, got.top_y);
            check_field("right_x", want.right_x, got.right_x);
            check_field("bottom_y", want.bottom_y, got.bottom_y);
            check_field("score", want.score, got.score);
            check_field("class_label", want.class_label, got.class_label);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("%0t: timeout, %0d boxes still pending", $time, pending_boxes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_thresholds();
      test_count_lowered();
      test_random_rows();
      drain_pipeline();

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: detection_row_decode.f
design/drd_pkg.sv
design/drd_stream_if.sv
design/detection_row_decode.sv
tb/testbench.sv
